FILE: hw/rtl/med2s_pkg.sv
// ----------------------------------------------------------------------------
// med2s_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// two-stream lower-median finder.
// ----------------------------------------------------------------------------
package med2s_pkg;

    localparam int DATA_W    = 32;
    localparam int CNTA_W    = 13;
    localparam int CNTB_W    = 20;
    localparam int TOT_W     = 21;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_B = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // write s_value into the store, bump load count
        logic emit_in;    // emit s_value as the answer
        logic take_b;     // latch the streamed element
        logic fetch;      // read the store at the walk pointer
        logic advance;    // step pointer and merged count, fetch the next entry
        logic close_b;    // streamed element takes its merged slot
        logic emit_b;     // emit the latched streamed element
        logic finish;     // second stream done: end job, latch tail address
        logic fetch_tail; // read the store at the tail address
        logic emit_rd;    // emit the store read data
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic a_ok;       // a stored element is wanted
        logic b_ok;       // a streamed element is wanted
        logic load_at_k;  // the element being loaded is the answer
        logic walk_le;    // current store entry is valid and not above the element
        logic at_k;       // merged count sits on the median position
        logic last_b;     // the element being closed is the last streamed one
        logic tail_ok;    // the answer lies in the store past the pointer
    } status_t;

endpackage

FILE: hw/rtl/med2s_ctrl.sv
// ----------------------------------------------------------------------------
// med2s_ctrl
// Sequencer for the merge walk: takes items, steps the store pointer and
// issues the tail read when the second stream runs out.
// ----------------------------------------------------------------------------
module med2s_ctrl
    import med2s_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_op,
    output logic    s_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_TFETCH = 4'b0100,
        ST_TEMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_op) begin
                        if (st.a_ok) begin
                            cmd.load    = 1'b1;
                            cmd.emit_in = st.load_at_k;
                        end
                    end else if (st.b_ok) begin
                        cmd.take_b = 1'b1;
                        cmd.fetch  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (st.walk_le) begin
                    if (st.at_k) begin
                        cmd.emit_rd = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        // pass this stored entry, fetch the next one
                        cmd.advance = 1'b1;
                        cmd.fetch   = 1'b1;
                    end
                end else begin
                    cmd.close_b = 1'b1;
                    state_next  = ST_IDLE;
                    if (st.at_k) begin
                        cmd.emit_b = 1'b1;
                    end else if (st.last_b) begin
                        cmd.finish = 1'b1;
                        if (st.tail_ok) begin
                            state_next = ST_TFETCH;
                        end
                    end
                end
            end
            ST_TFETCH: begin
                cmd.fetch_tail = 1'b1;
                state_next     = ST_TEMIT;
            end
            ST_TEMIT: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/med2s_dpath.sv
// ----------------------------------------------------------------------------
// med2s_dpath
// Store memory, job counters, config registers and the result register of
// the two-stream lower-median finder.
// ----------------------------------------------------------------------------
module med2s_dpath
    import med2s_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [DATA_W-1:0]     s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_median,
    input  cmd_t                  cmd,
    output status_t               st
);

    localparam int CNTA_MAX = (2 ** CNTA_W) - 1;
    localparam int NA_MAX   = (STORE_DEPTH < CNTA_MAX) ? STORE_DEPTH : CNTA_MAX;
    localparam int PTR_W    = $clog2(NA_MAX + 1);
    localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CNTA_W-1:0] NA_LIM = CNTA_W'(NA_MAX);

    logic [DATA_W-1:0] store_mem [STORE_DEPTH];

    logic [CNTA_W-1:0] count_a_reg;
    logic [CNTB_W-1:0] count_b_reg;
    logic [PTR_W-1:0]  load_cnt_reg;
    logic [PTR_W-1:0]  read_ptr_reg;
    logic [TOT_W-1:0]  merged_reg;
    logic [CNTB_W-1:0] seen_reg;
    logic              found_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_median_reg;
    logic [DATA_W-1:0] bval_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] tail_addr_reg;

    logic [CNTA_W-1:0] na_full;
    logic [PTR_W-1:0]  na;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  k;
    logic              job_empty;
    logic [TOT_W-1:0]  merged_inc;
    logic [TOT_W-1:0]  tail_idx;
    logic [PTR_W-1:0]  ptr_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic              emit_any;

    assign na_full    = (count_a_reg < NA_LIM) ? count_a_reg : NA_LIM;
    assign na         = PTR_W'(na_full);
    assign total      = TOT_W'(na) + TOT_W'(count_b_reg);
    assign job_empty  = (total == '0);
    assign k          = (total - TOT_W'(1)) >> 1;
    assign merged_inc = merged_reg + TOT_W'(1);
    assign tail_idx   = TOT_W'(read_ptr_reg) + (k - merged_inc);
    assign ptr_inc    = read_ptr_reg + PTR_W'(1);

    assign st.a_ok      = !job_empty && !found_reg && (load_cnt_reg < na);
    assign st.b_ok      = !job_empty && !found_reg && (seen_reg < count_b_reg);
    assign st.load_at_k = (count_b_reg == '0) && (TOT_W'(load_cnt_reg) == k);
    assign st.walk_le   = (read_ptr_reg < na) && ($signed(rdata_reg) <= $signed(bval_reg));
    assign st.at_k      = (merged_reg == k);
    assign st.last_b    = ((TOT_W'(seen_reg) + TOT_W'(1)) == TOT_W'(count_b_reg));
    assign st.tail_ok   = (merged_inc <= k) && (tail_idx < TOT_W'(na));

    assign emit_any = cmd.emit_in || cmd.emit_b || cmd.emit_rd;

    always_comb begin
        if (cmd.fetch_tail) begin
            rd_addr = tail_addr_reg;
        end else if (cmd.advance) begin
            rd_addr = ADDR_W'(ptr_inc);
        end else begin
            rd_addr = ADDR_W'(read_ptr_reg);
        end
    end

    // Store: one write port (loading), one registered read port (walk, tail)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            store_mem[ADDR_W'(load_cnt_reg)] <= s_value;
        end
        if (cmd.fetch || cmd.fetch_tail) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take_b) begin
            bval_reg <= s_value;
        end
        if (cmd.finish) begin
            tail_addr_reg <= ADDR_W'(tail_idx);
        end
        if (cmd.emit_in) begin
            m_median_reg <= s_value;
        end else if (cmd.emit_b) begin
            m_median_reg <= bval_reg;
        end else if (cmd.emit_rd) begin
            m_median_reg <= rdata_reg;
        end
    end

    // Job state and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            load_cnt_reg <= '0;
            read_ptr_reg <= '0;
            merged_reg   <= '0;
            seen_reg     <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit_any) begin
                m_valid_reg <= 1'b1;
                found_reg   <= 1'b1;
            end
            if (cmd.finish) begin
                found_reg <= 1'b1;
            end
            if (cmd.load) begin
                load_cnt_reg <= load_cnt_reg + PTR_W'(1);
            end
            if (cmd.advance) begin
                read_ptr_reg <= ptr_inc;
                merged_reg   <= merged_inc;
            end
            if (cmd.close_b) begin
                seen_reg   <= seen_reg + CNTB_W'(1);
                merged_reg <= merged_inc;
            end
            // a register write starts a new job
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_COUNT_A: count_a_reg <= cfg_data[CNTA_W-1:0];
                    CFG_COUNT_B: count_b_reg <= cfg_data[CNTB_W-1:0];
                    default:     count_a_reg <= count_a_reg;
                endcase
                load_cnt_reg <= '0;
                read_ptr_reg <= '0;
                merged_reg   <= '0;
                seen_reg     <= '0;
                found_reg    <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_any |-> !m_valid_reg)
        else $error("result emitted while previous result still pending");

    a_result_ends_job: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> found_reg)
        else $error("result shown without the job being marked done");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (read_ptr_reg <= na) && (load_cnt_reg <= na))
        else $error("store pointer ran past the loaded length");

    a_merged_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (!found_reg && !job_empty) |-> (merged_reg <= k))
        else $error("merge walk passed the median position");
`endif

endmodule

FILE: hw/rtl/median_of_two_sorted_streams.sv
// ----------------------------------------------------------------------------
// median_of_two_sorted_streams
// Lower median of two ascending sequences: the first is stored, the second
// streams past a merge walk over the store.
//
//   channel | ports                                 | direction
//   --------+---------------------------------------+----------
//   input   | s_valid s_ready s_op s_value          | in
//   result  | m_valid m_ready m_median              | out
//   config  | cfg_wr_en cfg_index cfg_data          | in
//
// A stored element is written into the store while idle. A streamed element
// is latched, then steps past each stored entry not above it, one registered
// store read per entry. A tail read adds the tail fetch and tail emit states.
// Synchronous active-low reset clears counters and config; the store is not
// cleared. A pending result does not stall input.
// ----------------------------------------------------------------------------
module median_of_two_sorted_streams
    import med2s_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [DATA_W-1:0]    s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_median
);

    cmd_t    cmd;
    status_t st;

    med2s_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    med2s_dpath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_median  (m_median),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
